// ----- hw/rtl/rbr_pkg.sv -----
// Shared types, codes and constants of the radial heightmap brush.
package rbr_pkg;

   localparam int DEF_MAP_WIDTH       = 256;
   localparam int DEF_MAP_HEIGHT      = 256;
   localparam int DEF_MAX_TILE_RADIUS = 15;
   localparam int DEF_HEIGHT_BITS     = 16;
   localparam int QUEUE_DEPTH         = 2;

   // Shared divider: 28-bit dividend, 12-bit divisor.
   localparam int DIV_W     = 28;
   localparam int DIVISOR_W = 12;
   // Square root of a 24-bit squared distance scaled by 2^32.
   localparam int SQRT_IN_W = 24;
   localparam int ROOT_W    = 28;

   localparam logic [16:0] FALLOFF_ONE     = 17'h10000;
   localparam logic [7:0]  TILE_SIZE_RESET = 8'd128;

   typedef enum logic [1:0] {
      CMD_WRITE  = 2'd0,
      CMD_READ   = 2'd1,
      CMD_BRUSH  = 2'd2,
      CMD_UNUSED = 2'd3
   } cmd_type;

   typedef enum logic {
      CSR_ENABLE    = 1'b0,
      CSR_TILE_SIZE = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      KIND_NOP,
      KIND_WRITE,
      KIND_READ,
      KIND_BRUSH,
      KIND_IGNORED
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic [15:0]        pos_x;
      logic [15:0]        pos_y;
      logic [11:0]        brush_radius;
      logic signed [15:0] strength;
      logic [7:0]         tile_x;
      logic [7:0]         tile_y;
      logic signed [15:0] height_in;
   } work_type;

   typedef struct packed {
      logic [15:0] height_out;
      logic        status;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WRITE,
      ST_READ,
      ST_DIV_CX,
      ST_DIV_CY,
      ST_DIV_TR,
      ST_SETUP,
      ST_TILE,
      ST_DIST,
      ST_CHECK,
      ST_SQRT,
      ST_DIV_Q,
      ST_MUL,
      ST_UPDATE,
      ST_NEXT,
      ST_RESULT
   } eng_state_type;

endpackage

// ----- hw/rtl/rbr_queue.sv -----
// Small first-in first-out queue of any packed item type.
module rbr_queue #(
   parameter int  DEPTH     = 2,
   parameter type item_type = logic
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type wdata,
   output logic     full,
   input  logic     pop,
   output item_type rdata,
   output logic     empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type          slots_ff [DEPTH];
   logic [PTR_W-1:0]  wptr_ff, wptr_in;
   logic [PTR_W-1:0]  rptr_ff, rptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = slots_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wptr_ff] <= wdata;
      end
   end
endmodule

// ----- hw/rtl/rbr_front.sv -----
// Front end: classifies incoming commands and queues them for the engine.
module rbr_front #(
   parameter int MAP_WIDTH  = rbr_pkg::DEF_MAP_WIDTH,
   parameter int MAP_HEIGHT = rbr_pkg::DEF_MAP_HEIGHT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               enable,
   input  logic               push,
   output logic               full,
   input  logic [1:0]         cmd,
   input  logic [15:0]        pos_x,
   input  logic [15:0]        pos_y,
   input  logic [11:0]        brush_radius,
   input  logic signed [15:0] strength,
   input  logic [7:0]         tile_x,
   input  logic [7:0]         tile_y,
   input  logic signed [15:0] height_in,
   input  logic               work_pop,
   output rbr_pkg::work_type  work_item,
   output logic               work_empty
);
   import rbr_pkg::*;

   work_type item;
   logic     on_map;

   assign on_map = (int'(tile_x) < MAP_WIDTH) && (int'(tile_y) < MAP_HEIGHT);

   // Off-map reads and writes and the unused code become no-ops here, so
   // the engine only sees work that touches the map or reports a status.
   always_comb begin
      item.pos_x        = pos_x;
      item.pos_y        = pos_y;
      item.brush_radius = brush_radius;
      item.strength     = strength;
      item.tile_x       = tile_x;
      item.tile_y       = tile_y;
      item.height_in    = height_in;
      case (cmd)
         CMD_WRITE: item.kind = on_map ? KIND_WRITE : KIND_NOP;
         CMD_READ:  item.kind = on_map ? KIND_READ : KIND_NOP;
         CMD_BRUSH: item.kind = enable ? KIND_BRUSH : KIND_IGNORED;
         default:   item.kind = KIND_NOP;
      endcase
   end

   rbr_queue #(
      .DEPTH     (QUEUE_DEPTH),
      .item_type (work_type)
   ) u_work_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata (item),
      .full  (full),
      .pop   (work_pop),
      .rdata (work_item),
      .empty (work_empty)
   );
endmodule

// ----- hw/rtl/rbr_divu.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
module rbr_divu (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [rbr_pkg::DIV_W-1:0]     dividend,
   input  logic [rbr_pkg::DIVISOR_W-1:0] divisor,
   output logic [rbr_pkg::DIV_W-1:0]     quotient,
   output logic                          done
);
   import rbr_pkg::*;

   localparam int CNT_W = $clog2(DIV_W);

   logic                 busy_ff, done_ff;
   logic [CNT_W-1:0]     count_ff;
   logic [DIVISOR_W-1:0] rem_ff, divisor_ff;
   logic [DIV_W-1:0]     quo_ff;
   logic [DIVISOR_W:0]   shifted, trial;
   logic                 fits;

   assign shifted  = {rem_ff, quo_ff[DIV_W-1]};
   assign trial    = shifted - {1'b0, divisor_ff};
   assign fits     = (shifted >= {1'b0, divisor_ff});
   assign quotient = quo_ff;
   assign done     = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
         end else if (busy_ff) begin
            count_ff <= count_ff + 1'b1;
            if (count_ff == CNT_W'(DIV_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff     <= '0;
         quo_ff     <= dividend;
         divisor_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
         quo_ff <= {quo_ff[DIV_W-2:0], fits};
      end
   end
endmodule

// ----- hw/rtl/rbr_sqrt.sv -----
// Digit-by-digit integer square root of a value scaled by 2^32, one bit per cycle.
module rbr_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [rbr_pkg::SQRT_IN_W-1:0] radicand,
   output logic [rbr_pkg::ROOT_W-1:0]    root,
   output logic                          done
);
   import rbr_pkg::*;

   localparam int N_W   = 2 * ROOT_W;
   localparam int REM_W = ROOT_W + 2;
   localparam int CNT_W = $clog2(ROOT_W);

   logic                 busy_ff, done_ff;
   logic [CNT_W-1:0]     count_ff;
   logic [N_W-1:0]       n_ff;
   logic [REM_W-1:0]     rem_ff, rem_shift, trial;
   logic [ROOT_W-1:0]    root_ff;
   logic                 fits;

   assign rem_shift = {rem_ff[REM_W-3:0], n_ff[N_W-1 -: 2]};
   assign trial     = {root_ff, 2'b01};
   assign fits      = (rem_shift >= trial);
   assign root      = root_ff;
   assign done      = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
         end else if (busy_ff) begin
            count_ff <= count_ff + 1'b1;
            if (count_ff == CNT_W'(ROOT_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         n_ff    <= {radicand, (N_W - SQRT_IN_W)'(0)};
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         n_ff    <= {n_ff[N_W-3:0], 2'b00};
         rem_ff  <= fits ? rem_shift - trial : rem_shift;
         root_ff <= {root_ff[ROOT_W-2:0], fits};
      end
   end
endmodule

// ----- hw/rtl/rbr_engine.sv -----
// Back end: executes queued commands against the heightmap memory.
module rbr_engine #(
   parameter int MAP_WIDTH       = rbr_pkg::DEF_MAP_WIDTH,
   parameter int MAP_HEIGHT      = rbr_pkg::DEF_MAP_HEIGHT,
   parameter int MAX_TILE_RADIUS = rbr_pkg::DEF_MAX_TILE_RADIUS,
   parameter int HEIGHT_BITS     = rbr_pkg::DEF_HEIGHT_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [7:0]        tile_size,
   input  logic              work_empty,
   input  rbr_pkg::work_type work_item,
   output logic              work_pop,
   input  logic              rsp_full,
   output logic              rsp_push,
   output rbr_pkg::rsp_type  rsp_item
);
   import rbr_pkg::*;

   localparam int DEPTH  = MAP_WIDTH * MAP_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int TR_W   = $clog2(MAX_TILE_RADIUS + 1);
   localparam int OFS_W  = TR_W + 1;
   localparam int DIST_W = 2 * TR_W + 1;
   localparam int D2_W   = DIST_W + 16;
   localparam int POS_W  = 18;
   localparam int SUM_W  = 34;
   localparam logic signed [SUM_W-1:0] H_MAX = SUM_W'((64'sd1 <<< (HEIGHT_BITS - 1)) - 64'sd1);
   localparam logic signed [SUM_W-1:0] H_MIN = -H_MAX - SUM_W'(1);
   localparam logic signed [POS_W-1:0] X_LIM = POS_W'(MAP_WIDTH);
   localparam logic signed [POS_W-1:0] Y_LIM = POS_W'(MAP_HEIGHT);
   localparam logic [TR_W-1:0]         TR_CAP = TR_W'(MAX_TILE_RADIUS);

   eng_state_type state_ff, state_in;

   work_type                 work_ff;
   logic [15:0]              cx_ff, cy_ff;
   logic [TR_W-1:0]          tr_ff;
   logic signed [OFS_W-1:0]  dx_ff, dy_ff, tr_s;
   logic [15:0]              ts2_ff;
   logic [23:0]              r2_ff;
   logic [DIST_W-1:0]        dist2_ff;
   logic [D2_W-1:0]          d2_ff;
   logic [16:0]              f_ff;
   logic signed [SUM_W-1:0]  prod_ff;
   logic [ADDR_W-1:0]        addr_ff;

   logic signed [HEIGHT_BITS-1:0] mem [DEPTH];
   logic signed [HEIGHT_BITS-1:0] rdata_ff;
   logic signed [HEIGHT_BITS-1:0] wdata;
   logic                          mem_we;

   logic                  div_start, div_done, sqrt_start, sqrt_done;
   logic [DIV_W-1:0]      div_dividend, div_quotient;
   logic [DIVISOR_W-1:0]  div_divisor;
   logic [ROOT_W-1:0]     root;

   logic signed [POS_W-1:0] tx, ty;
   logic                    tile_on_map, tile_miss, rad_zero;
   logic [TR_W-1:0]         adx, ady;
   logic [ADDR_W-1:0]       tile_addr, head_addr;
   logic signed [SUM_W-1:0] adj, chg, sum, wide;

   assign tr_s     = $signed({1'b0, tr_ff});
   assign rad_zero = (work_ff.brush_radius == '0);
   assign tx       = $signed({2'b00, cx_ff}) + POS_W'(dx_ff);
   assign ty       = $signed({2'b00, cy_ff}) + POS_W'(dy_ff);
   assign tile_on_map = !tx[POS_W-1] && !ty[POS_W-1] && (tx < X_LIM) && (ty < Y_LIM);
   assign adx = dx_ff[OFS_W-1] ? TR_W'(-dx_ff) : TR_W'(dx_ff);
   assign ady = dy_ff[OFS_W-1] ? TR_W'(-dy_ff) : TR_W'(dy_ff);
   assign tile_addr = ADDR_W'(ty) * ADDR_W'(MAP_WIDTH) + ADDR_W'(tx);
   assign head_addr = ADDR_W'(work_item.tile_y) * ADDR_W'(MAP_WIDTH)
                    + ADDR_W'(work_item.tile_x);
   assign tile_miss = (d2_ff > r2_ff);

   // Product is truncated toward zero before it is added to the height.
   assign adj = prod_ff + (prod_ff[SUM_W-1] ? SUM_W'(65535) : SUM_W'(0));
   assign chg = adj >>> 16;
   assign sum = SUM_W'(rdata_ff) + chg;
   assign wide = (state_ff == ST_WRITE) ? SUM_W'(work_ff.height_in) : sum;

   always_comb begin
      if (wide > H_MAX) begin
         wdata = HEIGHT_BITS'(H_MAX);
      end else if (wide < H_MIN) begin
         wdata = HEIGHT_BITS'(H_MIN);
      end else begin
         wdata = HEIGHT_BITS'(wide);
      end
   end

   assign rsp_item.height_out = (work_ff.kind == KIND_READ) ? 16'(rdata_ff) : '0;
   assign rsp_item.status     = (work_ff.kind == KIND_IGNORED);

   rbr_divu u_divu (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .done     (div_done)
   );

   rbr_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (SQRT_IN_W'(d2_ff)),
      .root     (root),
      .done     (sqrt_done)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!work_empty) begin
               case (work_item.kind)
                  KIND_WRITE: state_in = ST_WRITE;
                  KIND_READ:  state_in = ST_READ;
                  KIND_BRUSH: state_in = ST_DIV_CX;
                  default:    state_in = ST_RESULT;
               endcase
            end
         end
         ST_WRITE:  state_in = ST_RESULT;
         ST_READ:   state_in = ST_RESULT;
         ST_DIV_CX: if (div_done) state_in = ST_DIV_CY;
         ST_DIV_CY: if (div_done) state_in = ST_DIV_TR;
         ST_DIV_TR: if (div_done) state_in = ST_SETUP;
         ST_SETUP:  state_in = ST_TILE;
         ST_TILE:   state_in = tile_on_map ? ST_DIST : ST_NEXT;
         ST_DIST:   state_in = ST_CHECK;
         ST_CHECK: begin
            if (tile_miss) begin
               state_in = ST_NEXT;
            end else if (rad_zero) begin
               state_in = ST_MUL;
            end else begin
               state_in = ST_SQRT;
            end
         end
         ST_SQRT:   if (sqrt_done) state_in = ST_DIV_Q;
         ST_DIV_Q:  if (div_done) state_in = ST_MUL;
         ST_MUL:    state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_NEXT;
         ST_NEXT: begin
            if (dx_ff == tr_s && dy_ff == tr_s) begin
               state_in = ST_RESULT;
            end else begin
               state_in = ST_TILE;
            end
         end
         ST_RESULT: if (!rsp_full) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Strobes and operand selection.
   always_comb begin
      work_pop     = 1'b0;
      rsp_push     = 1'b0;
      mem_we       = 1'b0;
      div_start    = 1'b0;
      sqrt_start   = 1'b0;
      div_dividend = '0;
      div_divisor  = DIVISOR_W'(tile_size);
      case (state_ff)
         ST_IDLE: begin
            work_pop = !work_empty;
            if (!work_empty && work_item.kind == KIND_BRUSH) begin
               div_start    = 1'b1;
               div_dividend = DIV_W'(work_item.pos_x);
            end
         end
         ST_DIV_CX: begin
            div_start    = div_done;
            div_dividend = DIV_W'(work_ff.pos_y);
         end
         ST_DIV_CY: begin
            div_start    = div_done;
            div_dividend = DIV_W'(work_ff.brush_radius);
         end
         ST_CHECK:  sqrt_start = !tile_miss && !rad_zero;
         ST_SQRT: begin
            div_start    = sqrt_done;
            div_dividend = root;
            div_divisor  = work_ff.brush_radius;
         end
         ST_WRITE:  mem_we = 1'b1;
         ST_UPDATE: mem_we = 1'b1;
         ST_RESULT: rsp_push = !rsp_full;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            work_ff <= work_item;
            addr_ff <= head_addr;
         end
         ST_DIV_CX: if (div_done) cx_ff <= div_quotient[15:0];
         ST_DIV_CY: if (div_done) cy_ff <= div_quotient[15:0];
         ST_DIV_TR: begin
            if (div_done) begin
               tr_ff <= (div_quotient > DIV_W'(MAX_TILE_RADIUS)) ? TR_CAP
                                                                 : TR_W'(div_quotient);
            end
         end
         ST_SETUP: begin
            dx_ff  <= -tr_s;
            dy_ff  <= -tr_s;
            ts2_ff <= tile_size * tile_size;
            r2_ff  <= work_ff.brush_radius * work_ff.brush_radius;
         end
         ST_TILE: begin
            addr_ff  <= tile_addr;
            dist2_ff <= DIST_W'(adx * adx) + DIST_W'(ady * ady);
         end
         ST_DIST:  d2_ff <= dist2_ff * ts2_ff;
         ST_CHECK: f_ff  <= FALLOFF_ONE;
         ST_DIV_Q: begin
            if (div_done) begin
               f_ff <= (div_quotient >= DIV_W'(FALLOFF_ONE)) ? '0
                       : FALLOFF_ONE - 17'(div_quotient);
            end
         end
         ST_MUL:   prod_ff <= SUM_W'(work_ff.strength * $signed({1'b0, f_ff}));
         ST_NEXT: begin
            if (dx_ff == tr_s) begin
               dx_ff <= -tr_s;
               dy_ff <= dy_ff + 1'b1;
            end else begin
               dx_ff <= dx_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[addr_ff] <= wdata;
      end
      rdata_ff <= mem[addr_ff];
   end
endmodule

// ----- hw/rtl/radial_heightmap_brush.sv -----
// Top level of the radial heightmap brush: registers, front end, engine and result queue.
//
// The block holds a tile heightmap of signed Q8.8 heights. Commands enter on the
// req_ channel like pushes into a queue: a transfer happens when req_push is high
// and req_full is low. Results leave like pops: while rsp_empty is low the oldest
// result sits on rsp_height_out and rsp_status, and rsp_pop takes it.
// Every command gives exactly one result, in command order.
// A write or a read passes through its own state and then the result state. A brush
// runs three divisions to find its centre and tile radius, then walks up to (2R+1)^2
// tiles: an off-map tile is skipped, a missed tile is measured and checked, and a hit
// tile is dominated by the square root and the division on the shared divider, both
// skipped for a zero brush radius. A full brush, at the default radius cap, is 31 by 31.
// Two-entry queues sit on the command and result sides, so a few commands can
// wait while the engine works and finished results wait while the receiver stalls;
// the engine simply holds its last result until the result queue has room.
// The csr_ channel writes enable (index 0) and tile_size (index 1); it is always
// ready and must only be used while the block is idle. Reset empties both queues,
// clears enable and sets tile_size to 128. The map itself is not cleared: a read
// of a tile that was never written returns an undefined value.
module radial_heightmap_brush #(
   parameter int MAP_WIDTH       = rbr_pkg::DEF_MAP_WIDTH,
   parameter int MAP_HEIGHT      = rbr_pkg::DEF_MAP_HEIGHT,
   parameter int MAX_TILE_RADIUS = rbr_pkg::DEF_MAX_TILE_RADIUS,
   parameter int HEIGHT_BITS     = rbr_pkg::DEF_HEIGHT_BITS
) (
   input  logic               clock,
   input  logic               reset,
   // Command channel.
   input  logic               req_push,
   output logic               req_full,
   input  logic [1:0]         req_cmd,
   input  logic [15:0]        req_pos_x,
   input  logic [15:0]        req_pos_y,
   input  logic [11:0]        req_brush_radius,
   input  logic signed [15:0] req_strength,
   input  logic [7:0]         req_tile_x,
   input  logic [7:0]         req_tile_y,
   input  logic signed [15:0] req_height_in,
   // Result channel.
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic signed [15:0] rsp_height_out,
   output logic               rsp_status,
   // Register write channel.
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [7:0]         csr_wdata
);
   import rbr_pkg::*;

   logic       enable_ff, enable_in;
   logic [7:0] tile_size_ff, tile_size_in;
   logic [7:0] tile_size_eff;

   work_type work_item;
   logic     work_pop, work_empty;
   rsp_type  eng_rsp, rsp_head;
   logic     rsp_push, rsp_full;

   assign csr_ready = 1'b1;

   // Register writes are never stalled and take effect in the following cycle.
   always_comb begin
      enable_in    = enable_ff;
      tile_size_in = tile_size_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ENABLE:    enable_in    = csr_wdata[0];
            CSR_TILE_SIZE: tile_size_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         tile_size_ff <= TILE_SIZE_RESET;
      end else begin
         enable_ff    <= enable_in;
         tile_size_ff <= tile_size_in;
      end
   end

   // A tile size of zero behaves as one world unit per tile.
   assign tile_size_eff = (tile_size_ff == '0) ? 8'd1 : tile_size_ff;

   rbr_front #(
      .MAP_WIDTH  (MAP_WIDTH),
      .MAP_HEIGHT (MAP_HEIGHT)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .enable       (enable_ff),
      .push         (req_push),
      .full         (req_full),
      .cmd          (req_cmd),
      .pos_x        (req_pos_x),
      .pos_y        (req_pos_y),
      .brush_radius (req_brush_radius),
      .strength     (req_strength),
      .tile_x       (req_tile_x),
      .tile_y       (req_tile_y),
      .height_in    (req_height_in),
      .work_pop     (work_pop),
      .work_item    (work_item),
      .work_empty   (work_empty)
   );

   rbr_engine #(
      .MAP_WIDTH       (MAP_WIDTH),
      .MAP_HEIGHT      (MAP_HEIGHT),
      .MAX_TILE_RADIUS (MAX_TILE_RADIUS),
      .HEIGHT_BITS     (HEIGHT_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .tile_size  (tile_size_eff),
      .work_empty (work_empty),
      .work_item  (work_item),
      .work_pop   (work_pop),
      .rsp_full   (rsp_full),
      .rsp_push   (rsp_push),
      .rsp_item   (eng_rsp)
   );

   rbr_queue #(
      .DEPTH     (QUEUE_DEPTH),
      .item_type (rsp_type)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (eng_rsp),
      .full  (rsp_full),
      .pop   (rsp_pop),
      .rdata (rsp_head),
      .empty (rsp_empty)
   );

   assign rsp_height_out = $signed(rsp_head.height_out);
   assign rsp_status     = rsp_head.status;
endmodule
